@@ rtl/wmpf_pkg.sv @@
// shared types and constants for the windowed medoid position filter
`default_nettype none

package wmpf_pkg;

   // width of the window size register
   localparam int CFG_W  = 5;
   // saturating distance sum width
   localparam int SUM_W  = 56;
   // deviation width (n * sum - total)
   localparam int DEV_W  = 64;
   // squared deviation width
   localparam int SQ_W   = 128;
   // accumulator width: n * squared deviation, sum of squared deviations
   localparam int WIDE_W = 136;
   // multiplier operand and product widths
   localparam int MUL_W  = 32;
   localparam int PROD_W = 64;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // request action codes
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   // left shift applied to a product before it is accumulated
   typedef enum logic [2:0] {
      SH_0,
      SH_32,
      SH_33,
      SH_64,
      SH_96
   } shift_type;

   // one operation for the shared multiply-accumulate unit
   typedef struct packed {
      logic             valid;
      logic             clr;
      shift_type        sh;
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mac_op_type;

endpackage

`default_nettype wire

@@ rtl/wmpf_mac.sv @@
// shared multiply-accumulate unit: registered product, then shifted accumulate
`default_nettype none

module wmpf_mac (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire wmpf_pkg::mac_op_type        op,
   output logic [wmpf_pkg::WIDE_W-1:0]      acc
);
   import wmpf_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              pvld_ff;
   logic              pclr_ff;
   shift_type         psh_ff;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [WIDE_W-1:0] shifted;

   // one 32x32 multiply per cycle
   assign prod_in = PROD_W'(op.op_a) * PROD_W'(op.op_b);

   // align the product and add it in
   always_comb begin
      case (psh_ff)
         SH_0:    shifted = WIDE_W'(prod_ff);
         SH_32:   shifted = WIDE_W'(prod_ff) << 32;
         SH_33:   shifted = WIDE_W'(prod_ff) << 33;
         SH_64:   shifted = WIDE_W'(prod_ff) << 64;
         SH_96:   shifted = WIDE_W'(prod_ff) << 96;
         default: shifted = WIDE_W'(prod_ff);
      endcase
      acc_in = acc_ff;
      if (pvld_ff) begin
         acc_in = (pclr_ff ? {WIDE_W{1'b0}} : acc_ff) + shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= op.valid;
      end
      prod_ff <= prod_in;
      pclr_ff <= op.clr;
      psh_ff  <= op.sh;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ rtl/windowed_medoid_position_filter_unit.sv @@
// top level: sample store, sequencer and medoid selection over one shared mac
// a pass-through request is answered from the response register; a clear request gives no response;
//   a filtered request for n stored samples runs two distance passes of 3*n*n ops each and the
//   per-slot statistics steps, all on the single multiply-accumulate unit
// throughput: one request at a time; no new request is taken until the result is out
// reset: synchronous, clears window size, fill count and write slot; stores are not cleared
`default_nettype none

module windowed_medoid_position_filter_unit #(
   parameter int WINDOW_MAX = 16,
   parameter int COORD_BITS = 24
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [wmpf_pkg::CFG_W-1:0]     csr_wr_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_action,
   input  wire logic signed [COORD_BITS-1:0]   req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]   req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]   req_pos_z,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [COORD_BITS-1:0]        rsp_best_x,
   output logic signed [COORD_BITS-1:0]        rsp_best_y,
   output logic signed [COORD_BITS-1:0]        rsp_best_z,
   output logic                                rsp_filtered
);
   import wmpf_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int ROW_W = 3 * COORD_BITS;
   localparam logic [CNT_W-1:0] MIN_WIN = CNT_W'(3);

   // statistics micro-steps
   localparam logic [3:0] STP_NS_LO  = 4'd1;
   localparam logic [3:0] STP_NS_HI  = 4'd2;
   localparam logic [3:0] STP_DEV    = 4'd4;
   localparam logic [3:0] STP_SQ_LL  = 4'd5;
   localparam logic [3:0] STP_SQ_LH  = 4'd6;
   localparam logic [3:0] STP_SQ_HH  = 4'd7;
   localparam logic [3:0] STP_SQ     = 4'd9;
   localparam logic [3:0] STP_SC_0   = 4'd10;
   localparam logic [3:0] STP_SC_1   = 4'd11;
   localparam logic [3:0] STP_SC_2   = 4'd12;
   localparam logic [3:0] STP_SC_3   = 4'd13;
   localparam logic [3:0] STP_KEEP   = 4'd15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM_A,
      ST_STAT_B,
      ST_STAT_C,
      ST_SUM_D,
      ST_FETCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [1:0]       coord;
      logic             first;
      logic             last;
      logic             final_op;
      logic             gate;
   } tag_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  win_ff, win_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  wslot_ff, wslot_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [1:0]        c_ff, c_in;
   logic [3:0]        step_ff, step_in;
   logic              issue_done_ff, issue_done_in;
   logic [DEV_W-1:0]  total_ff, total_in;
   logic [WIDE_W-1:0] var_ff, var_in;
   logic [DEV_W-1:0]  dev_ff, dev_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [WINDOW_MAX-1:0] kept_ff, kept_in;
   logic              any_ff, any_in;
   logic              have_ff, have_in;
   logic [SUM_W-1:0]  best_sum_ff, best_sum_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   tag_type           t1_ff, t1_in, t2_ff, t3_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic              rsp_filt_ff, rsp_filt_in;

   // sample store and distance sum store
   logic [ROW_W-1:0]  smp_mem [WINDOW_MAX];
   logic              smp_we;
   logic [IDX_W-1:0]  smp_waddr;
   logic [ROW_W-1:0]  smp_wdata;
   logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;
   logic [ROW_W-1:0]  row_a_ff, row_b_ff;
   logic [SUM_W-1:0]  dist_mem [WINDOW_MAX];
   logic              dist_we;
   logic [SUM_W-1:0]  dist_rd_ff;

   logic [CNT_W-1:0]  eff;
   logic              req_take;
   logic              rsp_free;
   logic              j_last, i_last, ab_last;
   logic [IDX_W-1:0]  slot;
   logic [COORD_BITS-1:0] coord_a, coord_b;
   logic [COORD_BITS:0]   diff;
   logic [COORD_BITS-1:0] mag;
   logic [SUM_W-1:0]  s_sat;
   logic              keep_now;
   mac_op_type        mac_op;
   logic [WIDE_W-1:0] acc;

   wmpf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (acc)
   );

   // effective window, clamped to the store depth
   assign eff = (32'(win_ff) > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(win_ff);

   // handshakes
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !rsp_free;
   assign req_take  = req_valid && !req_stall;

   // loop ends
   assign j_last  = (CNT_W'(j_ff) + CNT_W'(1)) == n_ff;
   assign i_last  = (CNT_W'(i_ff) + CNT_W'(1)) == n_ff;
   assign ab_last = j_last && (c_ff == 2'd2);

   // read addresses
   assign rd_a_addr = ((state_ff == ST_FETCH) || (state_ff == ST_RESULT)) ? best_ff : i_ff;
   assign rd_b_addr = j_ff;

   // coordinate of the pair under work, absolute difference
   always_comb begin
      case (t1_ff.coord)
         2'd0: begin
            coord_a = row_a_ff[COORD_BITS-1:0];
            coord_b = row_b_ff[COORD_BITS-1:0];
         end
         2'd1: begin
            coord_a = row_a_ff[2*COORD_BITS-1:COORD_BITS];
            coord_b = row_b_ff[2*COORD_BITS-1:COORD_BITS];
         end
         default: begin
            coord_a = row_a_ff[3*COORD_BITS-1:2*COORD_BITS];
            coord_b = row_b_ff[3*COORD_BITS-1:2*COORD_BITS];
         end
      endcase
      diff = {coord_a[COORD_BITS-1], coord_a} - {coord_b[COORD_BITS-1], coord_b};
      mag  = diff[COORD_BITS] ? COORD_BITS'(~diff + 1'b1) : diff[COORD_BITS-1:0];
   end

   // saturated distance sum from the accumulator
   assign s_sat    = (|acc[WIDE_W-1:SUM_W]) ? SUM_MAX : acc[SUM_W-1:0];
   assign keep_now = acc < var_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      wslot_in      = wslot_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      c_in          = c_ff;
      step_in       = step_ff;
      issue_done_in = issue_done_ff;
      total_in      = total_ff;
      var_in        = var_ff;
      dev_in        = dev_ff;
      sq_in         = sq_ff;
      kept_in       = kept_ff;
      any_in        = any_ff;
      have_in       = have_ff;
      best_sum_in   = best_sum_ff;
      best_in       = best_ff;
      t1_in         = '0;
      mac_op        = '0;
      smp_we        = 1'b0;
      smp_waddr     = fill_ff[IDX_W-1:0];
      smp_wdata     = {req_pos_z, req_pos_y, req_pos_x};
      dist_we       = 1'b0;
      slot          = '0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_filt_in   = rsp_filt_ff;

      // result taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register write
      if (csr_wr_en) begin
         win_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_CLEAR) begin
                  fill_in  = '0;
                  wslot_in = '0;
               end else if (eff < MIN_WIN) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = req_pos_x;
                  rsp_y_in     = req_pos_y;
                  rsp_z_in     = req_pos_z;
                  rsp_filt_in  = 1'b0;
               end else if (fill_ff < eff) begin
                  // still filling: append
                  smp_we    = 1'b1;
                  smp_waddr = fill_ff[IDX_W-1:0];
                  fill_in   = fill_ff + CNT_W'(1);
                  if ((fill_ff + CNT_W'(1)) < eff) begin
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = req_pos_x;
                     rsp_y_in     = req_pos_y;
                     rsp_z_in     = req_pos_z;
                     rsp_filt_in  = 1'b0;
                  end else begin
                     wslot_in      = '0;
                     n_in          = fill_ff + CNT_W'(1);
                     i_in          = '0;
                     j_in          = '0;
                     c_in          = '0;
                     issue_done_in = 1'b0;
                     total_in      = '0;
                     state_in      = ST_SUM_A;
                  end
               end else begin
                  // full: replace the oldest slot
                  slot      = (CNT_W'(wslot_ff) >= fill_ff) ? '0 : wslot_ff;
                  smp_we    = 1'b1;
                  smp_waddr = slot;
                  wslot_in  = ((CNT_W'(slot) + CNT_W'(1)) >= fill_ff) ? '0
                                                                      : slot + IDX_W'(1);
                  n_in          = fill_ff;
                  i_in          = '0;
                  j_in          = '0;
                  c_in          = '0;
                  issue_done_in = 1'b0;
                  total_in      = '0;
                  state_in      = ST_SUM_A;
               end
            end
         end

         ST_SUM_A, ST_SUM_D: begin
            // issue one squared coordinate difference per cycle
            if (!issue_done_ff) begin
               t1_in.valid    = 1'b1;
               t1_in.idx      = i_ff;
               t1_in.coord    = c_ff;
               t1_in.first    = (j_ff == '0) && (c_ff == 2'd0);
               t1_in.last     = ab_last;
               t1_in.final_op = ab_last && i_last;
               t1_in.gate     = (state_ff == ST_SUM_D) ? (kept_ff[i_ff] && kept_ff[j_ff]) : 1'b1;
               if (c_ff == 2'd2) begin
                  c_in = '0;
                  if (j_last) begin
                     j_in = '0;
                     if (i_last) begin
                        issue_done_in = 1'b1;
                     end else begin
                        i_in = i_ff + IDX_W'(1);
                     end
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end else begin
                  c_in = c_ff + 2'd1;
               end
            end
            mac_op.valid = t1_ff.valid;
            mac_op.clr   = t1_ff.first;
            mac_op.sh    = SH_0;
            mac_op.op_a  = t1_ff.gate ? MUL_W'(mag) : '0;
            mac_op.op_b  = t1_ff.gate ? MUL_W'(mag) : '0;
            // retire a finished slot sum
            if (t3_ff.valid && t3_ff.last) begin
               if (state_ff == ST_SUM_A) begin
                  dist_we  = 1'b1;
                  total_in = total_ff + DEV_W'(s_sat);
               end else if (kept_ff[t3_ff.idx] && (!have_ff || (s_sat < best_sum_ff))) begin
                  have_in     = 1'b1;
                  best_sum_in = s_sat;
                  best_in     = t3_ff.idx;
               end
               if (t3_ff.final_op) begin
                  if (state_ff == ST_SUM_A) begin
                     state_in = ST_STAT_B;
                     i_in     = '0;
                     step_in  = '0;
                     var_in   = '0;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end

         ST_STAT_B, ST_STAT_C: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               STP_NS_LO: begin
                  mac_op.valid = 1'b1;
                  mac_op.clr   = 1'b1;
                  mac_op.sh    = SH_0;
                  mac_op.op_a  = dist_rd_ff[MUL_W-1:0];
                  mac_op.op_b  = MUL_W'(n_ff);
               end
               STP_NS_HI: begin
                  mac_op.valid = 1'b1;
                  mac_op.sh    = SH_32;
                  mac_op.op_a  = MUL_W'(dist_rd_ff[SUM_W-1:MUL_W]);
                  mac_op.op_b  = MUL_W'(n_ff);
               end
               STP_DEV: begin
                  dev_in = (acc[DEV_W-1:0] >= total_ff) ? acc[DEV_W-1:0] - total_ff
                                                        : total_ff - acc[DEV_W-1:0];
               end
               STP_SQ_LL: begin
                  mac_op.valid = 1'b1;
                  mac_op.clr   = 1'b1;
                  mac_op.sh    = SH_0;
                  mac_op.op_a  = dev_ff[31:0];
                  mac_op.op_b  = dev_ff[31:0];
               end
               STP_SQ_LH: begin
                  mac_op.valid = 1'b1;
                  mac_op.sh    = SH_33;
                  mac_op.op_a  = dev_ff[31:0];
                  mac_op.op_b  = dev_ff[63:32];
               end
               STP_SQ_HH: begin
                  mac_op.valid = 1'b1;
                  mac_op.sh    = SH_64;
                  mac_op.op_a  = dev_ff[63:32];
                  mac_op.op_b  = dev_ff[63:32];
               end
               STP_SQ: begin
                  if (state_ff == ST_STAT_B) begin
                     var_in  = var_ff + acc;
                     step_in = '0;
                     if (i_last) begin
                        state_in = ST_STAT_C;
                        i_in     = '0;
                        kept_in  = '0;
                        any_in   = 1'b0;
                     end else begin
                        i_in = i_ff + IDX_W'(1);
                     end
                  end else begin
                     sq_in = acc[SQ_W-1:0];
                  end
               end
               STP_SC_0: begin
                  mac_op.valid = 1'b1;
                  mac_op.clr   = 1'b1;
                  mac_op.sh    = SH_0;
                  mac_op.op_a  = sq_ff[31:0];
                  mac_op.op_b  = MUL_W'(n_ff);
               end
               STP_SC_1: begin
                  mac_op.valid = 1'b1;
                  mac_op.sh    = SH_32;
                  mac_op.op_a  = sq_ff[63:32];
                  mac_op.op_b  = MUL_W'(n_ff);
               end
               STP_SC_2: begin
                  mac_op.valid = 1'b1;
                  mac_op.sh    = SH_64;
                  mac_op.op_a  = sq_ff[95:64];
                  mac_op.op_b  = MUL_W'(n_ff);
               end
               STP_SC_3: begin
                  mac_op.valid = 1'b1;
                  mac_op.sh    = SH_96;
                  mac_op.op_a  = sq_ff[127:96];
                  mac_op.op_b  = MUL_W'(n_ff);
               end
               STP_KEEP: begin
                  kept_in[i_ff] = keep_now;
                  any_in        = any_ff || keep_now;
                  step_in       = '0;
                  if (i_last) begin
                     // nothing kept: every slot counts
                     if (!(any_ff || keep_now)) begin
                        kept_in = '1;
                     end
                     state_in      = ST_SUM_D;
                     i_in          = '0;
                     j_in          = '0;
                     c_in          = '0;
                     issue_done_in = 1'b0;
                     have_in       = 1'b0;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end

         ST_FETCH: begin
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = row_a_ff[COORD_BITS-1:0];
               rsp_y_in     = row_a_ff[2*COORD_BITS-1:COORD_BITS];
               rsp_z_in     = row_a_ff[3*COORD_BITS-1:2*COORD_BITS];
               rsp_filt_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         win_ff        <= '0;
         fill_ff       <= '0;
         wslot_ff      <= '0;
         issue_done_ff <= 1'b0;
         t1_ff         <= '0;
         t2_ff         <= '0;
         t3_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         have_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         win_ff        <= win_in;
         fill_ff       <= fill_in;
         wslot_ff      <= wslot_in;
         issue_done_ff <= issue_done_in;
         t1_ff         <= t1_in;
         t2_ff         <= t1_ff;
         t3_ff         <= t2_ff;
         rsp_valid_ff  <= rsp_valid_in;
         have_ff       <= have_in;
      end
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      c_ff        <= c_in;
      step_ff     <= step_in;
      total_ff    <= total_in;
      var_ff      <= var_in;
      dev_ff      <= dev_in;
      sq_ff       <= sq_in;
      kept_ff     <= kept_in;
      any_ff      <= any_in;
      best_sum_ff <= best_sum_in;
      best_ff     <= best_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_filt_ff <= rsp_filt_in;
   end

   // sample store: one write, two registered reads
   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[smp_waddr] <= smp_wdata;
      end
      row_a_ff <= smp_mem[rd_a_addr];
      row_b_ff <= smp_mem[rd_b_addr];
   end

   // distance sum store: one write, one registered read
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[t3_ff.idx] <= s_sat;
      end
      dist_rd_ff <= dist_mem[i_ff];
   end

   // outputs
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_x   = rsp_x_ff;
   assign rsp_best_y   = rsp_y_ff;
   assign rsp_best_z   = rsp_z_ff;
   assign rsp_filtered = rsp_filt_ff;

`ifndef SYNTHESIS
   // the fill count never exceeds the store depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(WINDOW_MAX))
      else $error("fill count beyond store depth");

   // the replacement slot stays inside the filled part of the store
   a_wslot_range: assert property (@(posedge clock) disable iff (reset)
      (wslot_ff == '0) || (CNT_W'(wslot_ff) < fill_ff))
      else $error("write slot outside filled store");

   // sum pipeline is only busy in a distance pass
   a_tag_state: assert property (@(posedge clock) disable iff (reset)
      t3_ff.valid |-> ((state_ff == ST_SUM_A) || (state_ff == ST_SUM_D)))
      else $error("distance op retired outside a distance pass");

   // a filtered result always comes from a chosen stored slot
   a_best_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT) |-> (have_ff && (CNT_W'(best_ff) < n_ff)))
      else $error("no valid slot chosen for result");
`endif

endmodule

`default_nettype wire
